>>> rtl/svpd_pkg.sv
`default_nettype none
package svpd_pkg;

  localparam int FRAC_BITS_DEF = 15;
  localparam int MW            = 39;
  localparam int XW            = 40;

  localparam logic signed [21:0] SQRT3_Q20 = 22'sd1816187;

  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;
  localparam logic [2:0] SECTOR_7 = 3'd7;

  typedef struct packed {
    logic [2:0]    sector;
    logic          limited;
    logic [MW-1:0] m;
    logic [MW-1:0] s;
  } svpd_tag_t;

endpackage
`default_nettype wire

>>> rtl/svpd_div2.sv
`default_nettype none
module svpd_div2 #(
  parameter int QW = svpd_pkg::FRAC_BITS_DEF + 22
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_vld,
  input  wire [svpd_pkg::MW:0]      in_den,
  input  wire svpd_pkg::svpd_tag_t  in_tag,
  output logic                      out_vld,
  output logic [QW-1:0]             out_qm,
  output logic [QW-1:0]             out_qs,
  output svpd_pkg::svpd_tag_t       out_tag
);

  localparam int RW = svpd_pkg::MW + 2;

  logic                      vld_r [QW];
  logic [RW-1:0]             den_r [QW];
  logic [RW-1:0]             rm_r  [QW];
  logic [RW-1:0]             rs_r  [QW];
  logic [QW-1:0]             qm_r  [QW];
  logic [QW-1:0]             qs_r  [QW];
  svpd_pkg::svpd_tag_t       tag_r [QW];

  logic [RW-1:0]             rm_nxt [QW];
  logic [RW-1:0]             rs_nxt [QW];
  logic [QW-1:0]             qm_nxt [QW];
  logic [QW-1:0]             qs_nxt [QW];
  logic [RW-1:0]             den_in;
  logic [RW-1:0]             nm_in;
  logic [RW-1:0]             ns_in;

  function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic [RW-1:0] d);
    logic [RW-1:0] r2;
    r2 = {r[RW-2:0], 1'b0};
    if (r2 >= d) begin
      return {1'b1, r2 - d};
    end
    return {1'b0, r2};
  endfunction

  assign den_in = RW'(in_den);
  assign nm_in  = RW'(in_tag.m);
  assign ns_in  = RW'(in_tag.s);

  always_comb begin
    logic [RW:0] sm;
    logic [RW:0] ss;
    if (nm_in >= den_in) begin
      rm_nxt[0] = nm_in - den_in;
      qm_nxt[0] = QW'(1);
    end else begin
      rm_nxt[0] = nm_in;
      qm_nxt[0] = '0;
    end
    if (ns_in >= den_in) begin
      rs_nxt[0] = ns_in - den_in;
      qs_nxt[0] = QW'(1);
    end else begin
      rs_nxt[0] = ns_in;
      qs_nxt[0] = '0;
    end
    for (int k = 1; k < QW; k++) begin
      sm = div_step(rm_r[k-1], den_r[k-1]);
      ss = div_step(rs_r[k-1], den_r[k-1]);
      rm_nxt[k] = sm[RW-1:0];
      rs_nxt[k] = ss[RW-1:0];
      qm_nxt[k] = {qm_r[k-1][QW-2:0], sm[RW]};
      qs_nxt[k] = {qs_r[k-1][QW-2:0], ss[RW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < QW; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= den_in;
    tag_r[0] <= in_tag;
    for (int k = 1; k < QW; k++) begin
      den_r[k] <= den_r[k-1];
      tag_r[k] <= tag_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      rm_r[k] <= rm_nxt[k];
      rs_r[k] <= rs_nxt[k];
      qm_r[k] <= qm_nxt[k];
      qs_r[k] <= qs_nxt[k];
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_qm  = qm_r[QW-1];
  assign out_qs  = qs_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule
`default_nettype wire

>>> rtl/space_vector_pwm_duty.sv
`default_nettype none
// Space vector PWM duty generator.
// A word of alpha/beta voltage (signed, 2^FRAC_BITS is 1.0) is taken at a rising
// edge at which start is high and busy is low. Busy is high only during reset,
// so a new word may be given in every cycle.
// Each word gives one result word: three phase duties, the sector code and the
// overmodulation flag, shown for a single cycle with out_valid high.
// Most pipeline stages belong to the restoring divider, which spends one stage
// on each of its FRAC_BITS + 22 quotient bits; six further stages surround it.
// Throughput is one word per cycle at any FRAC_BITS.
// Reset clears all valid bits, so no result appears for words in flight.
// The receiver cannot stall the block, and results are never held back.
module space_vector_pwm_duty #(
  parameter int FRAC_BITS = svpd_pkg::FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire signed [15:0]  in_alpha_voltage,
  input  wire signed [15:0]  in_beta_voltage,
  output logic               out_valid,
  output logic [15:0]        out_duty_a,
  output logic [15:0]        out_duty_b,
  output logic [15:0]        out_duty_c,
  output logic [2:0]         out_sector_code,
  output logic               out_was_limited
);

  localparam int MW = svpd_pkg::MW;
  localparam int XW = svpd_pkg::XW;
  localparam int TIME_SHIFT = FRAC_BITS + 21;
  localparam int QW = TIME_SHIFT + 1;
  localparam int TW = (TIME_SHIFT + 3 > 42) ? TIME_SHIFT + 3 : 42;
  localparam logic [TW-1:0] ONE = TW'(1) << TIME_SHIFT;
  localparam logic [TW-1:0] TWO = TW'(1) << (TIME_SHIFT + 1);
  localparam logic [TW-1:0] RND = TW'(1) << 21;
  localparam logic [TW-1:0] FULL = TW'(1) << FRAC_BITS;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  logic                      s1_vld_r;
  logic signed [37:0]        bs_r;
  logic signed [17:0]        a3_r;
  logic signed [37:0]        bs_nxt;
  logic signed [17:0]        a3_nxt;

  assign bs_nxt = in_beta_voltage * svpd_pkg::SQRT3_Q20;
  assign a3_nxt = 18'(in_alpha_voltage) * 18'sd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    bs_r <= bs_nxt;
    a3_r <= a3_nxt;
  end

  logic                      s2_vld_r;
  logic signed [XW-1:0]      x_r, y_r, z_r;
  logic [2:0]                sec_r;
  logic signed [XW-1:0]      bsx, a20x, x_nxt, y_nxt, z_nxt;
  logic [2:0]                sec_nxt;

  always_comb begin
    bsx     = XW'(bs_r);
    a20x    = XW'($signed({a3_r, 20'b0}));
    x_nxt   = bsx <<< 1;
    y_nxt   = a20x + bsx;
    z_nxt   = bsx - a20x;
    sec_nxt = {y_nxt[XW-1], z_nxt[XW-1], (bs_r > 0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    sec_r <= sec_nxt;
  end

  logic                      s3_vld_r;
  svpd_pkg::svpd_tag_t       s3_tag_r;
  logic [MW:0]               s3_sum_r;
  logic signed [XW-1:0]      mv, sv;
  svpd_pkg::svpd_tag_t       s3_tag_nxt;
  logic [MW:0]               sum_nxt;

  always_comb begin
    case (sec_r)
      svpd_pkg::SECTOR_1: begin mv = z_r;  sv = y_r;  end
      svpd_pkg::SECTOR_2: begin mv = y_r;  sv = -x_r; end
      svpd_pkg::SECTOR_3: begin mv = -z_r; sv = x_r;  end
      svpd_pkg::SECTOR_4: begin mv = -x_r; sv = z_r;  end
      svpd_pkg::SECTOR_5: begin mv = x_r;  sv = -y_r; end
      default:            begin mv = -y_r; sv = -z_r; end
    endcase
    s3_tag_nxt.sector  = sec_r;
    s3_tag_nxt.m       = (mv > 0) ? MW'(mv) : '0;
    s3_tag_nxt.s       = (sv > 0) ? MW'(sv) : '0;
    sum_nxt            = (MW + 1)'(s3_tag_nxt.m) + (MW + 1)'(s3_tag_nxt.s);
    s3_tag_nxt.limited = TW'(sum_nxt) > ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_tag_r <= s3_tag_nxt;
    s3_sum_r <= sum_nxt;
  end

  logic                      dv_vld;
  logic [QW-1:0]             dv_qm, dv_qs;
  svpd_pkg::svpd_tag_t       dv_tag;

  svpd_div2 #(
    .QW (QW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s3_vld_r),
    .in_den  (s3_sum_r),
    .in_tag  (s3_tag_r),
    .out_vld (dv_vld),
    .out_qm  (dv_qm),
    .out_qs  (dv_qs),
    .out_tag (dv_tag)
  );

  logic                      p1_vld_r;
  logic [TW-1:0]             p1_m_r, p1_s_r, p1_mps_r;
  logic [2:0]                p1_sec_r;
  logic                      p1_lim_r;
  logic [TW-1:0]             m_nxt, s_nxt;

  always_comb begin
    if (dv_tag.limited) begin
      m_nxt = TW'(dv_qm);
      s_nxt = TW'(dv_qs);
    end else begin
      m_nxt = TW'(dv_tag.m);
      s_nxt = TW'(dv_tag.s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_m_r   <= m_nxt;
    p1_s_r   <= s_nxt;
    p1_mps_r <= m_nxt + s_nxt;
    p1_sec_r <= dv_tag.sector;
    p1_lim_r <= dv_tag.limited;
  end

  logic                      p2_vld_r;
  logic [TW-1:0]             ta_r, tb_r, tc_r;
  logic [2:0]                p2_sec_r;
  logic                      p2_lim_r;
  logic [TW-1:0]             ta_nxt;

  assign ta_nxt = (p1_mps_r >= ONE) ? '0 : ONE - p1_mps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ta_r     <= ta_nxt;
    tb_r     <= ta_nxt + (p1_m_r << 1);
    tc_r     <= ta_nxt + (p1_mps_r << 1);
    p2_sec_r <= p1_sec_r;
    p2_lim_r <= p1_lim_r;
  end

  function automatic logic [15:0] to_duty(input logic [TW-1:0] t);
    logic [TW-1:0] d2;
    logic [TW-1:0] q;
    d2 = (t >= TWO) ? '0 : TWO - t;
    q  = (d2 + RND) >> 22;
    if (q > FULL) begin
      q = FULL;
    end
    return q[15:0];
  endfunction

  logic [TW-1:0] c1, c2, c3;

  always_comb begin
    case (p2_sec_r)
      svpd_pkg::SECTOR_1: begin c1 = tb_r; c2 = ta_r; c3 = tc_r; end
      svpd_pkg::SECTOR_2: begin c1 = ta_r; c2 = tc_r; c3 = tb_r; end
      svpd_pkg::SECTOR_3: begin c1 = ta_r; c2 = tb_r; c3 = tc_r; end
      svpd_pkg::SECTOR_4: begin c1 = tc_r; c2 = tb_r; c3 = ta_r; end
      svpd_pkg::SECTOR_5: begin c1 = tc_r; c2 = ta_r; c3 = tb_r; end
      svpd_pkg::SECTOR_6: begin c1 = tb_r; c2 = tc_r; c3 = ta_r; end
      default:            begin c1 = '0;   c2 = '0;   c3 = '0;   end
    endcase
  end

  logic        out_valid_r;
  logic [15:0] duty_a_r, duty_b_r, duty_c_r;
  logic [2:0]  sector_r;
  logic        limited_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    duty_a_r  <= to_duty(c1);
    duty_b_r  <= to_duty(c2);
    duty_c_r  <= to_duty(c3);
    sector_r  <= p2_sec_r;
    limited_r <= p2_lim_r;
  end

  assign out_valid       = out_valid_r;
  assign out_duty_a      = duty_a_r;
  assign out_duty_b      = duty_b_r;
  assign out_duty_c      = duty_c_r;
  assign out_sector_code = sector_r;
  assign out_was_limited = limited_r;

endmodule
`default_nettype wire

>>> rtl/svpd_checker.sv
`default_nettype none
module svpd_checker #(
  parameter int LAT = svpd_pkg::FRAC_BITS_DEF + 28
) (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire [15:0] out_duty_a,
  input wire [15:0] out_duty_b,
  input wire [15:0] out_duty_c,
  input wire [2:0]  out_sector_code,
  input wire        out_was_limited
);

  a_one_result_per_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, LAT))
    else $error("result strobe does not match an accepted word");

  a_no_sector_seven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sector_code != svpd_pkg::SECTOR_7)
    else $error("impossible sector code");

  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sector_code == svpd_pkg::SECTOR_0) |->
      (out_duty_a == out_duty_b && out_duty_b == out_duty_c && !out_was_limited))
    else $error("zero vector gives unequal duties or a limit");

  a_busy_only_in_reset: assert property (@(posedge clk)
    rst_n |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind space_vector_pwm_duty svpd_checker #(
  .LAT (FRAC_BITS + 28)
) u_svpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_duty_a      (out_duty_a),
  .out_duty_b      (out_duty_b),
  .out_duty_c      (out_duty_c),
  .out_sector_code (out_sector_code),
  .out_was_limited (out_was_limited)
);
`default_nettype wire
